@@ src/hcbe_pkg.sv @@
// Shared types, constants and helpers for the chunked body encoder.
`default_nettype none
package hcbe_pkg;

  localparam int unsigned CFG_W          = 6;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 3;
  localparam int unsigned CHUNK_SIZE_RST = 10;

  localparam logic REG_CHUNK_SIZE = 1'b0;

  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_ZERO = 8'h30;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_HEX_HI = 13'b0000000000010,
    ST_HEX_LO = 13'b0000000000100,
    ST_CR1    = 13'b0000000001000,
    ST_LF1    = 13'b0000000010000,
    ST_DATA   = 13'b0000000100000,
    ST_CR2    = 13'b0000001000000,
    ST_LF2    = 13'b0000010000000,
    ST_Z0     = 13'b0000100000000,
    ST_ZCR1   = 13'b0001000000000,
    ST_ZLF1   = 13'b0010000000000,
    ST_ZCR2   = 13'b0100000000000,
    ST_ZLF2   = 13'b1000000000000
  } seq_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h57 + {4'h0, d};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/hcbe_if.sv @@
// Request channel interfaces: body input and encoded byte output.
`default_nettype none
interface hcbe_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source(output valid, func, data_byte, input ready);
  modport sink(input valid, func, data_byte, output ready);
endinterface

interface hcbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       body_done;
  modport source(output valid, out_byte, last, body_done, input ready);
  modport sink(input valid, out_byte, last, body_done, output ready);
endinterface
`default_nettype wire

@@ src/http_chunked_body_encoder.sv @@
// Chunked transfer encoder top: body bytes in, framed chunk stream out.
// The completing request updates the state register; the first byte then loads obyte.
// Output: one encoded byte per cycle while dout.ready is high; din.ready stays low while a
//   chunk frame or the end-of-body terminator is sent; other requests fill the buffer.
// The output rate is set by the single byte-wide output register fed by the buffer read port.
// Reset (rst, synchronous): empties the buffer count, sets chunk_size to 10 (or MAX_CHUNK); no memory clear.
`default_nettype none
module http_chunked_body_encoder #(
  parameter int unsigned MAX_CHUNK = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [hcbe_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [hcbe_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [hcbe_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  hcbe_in_if.sink                                  din,
  hcbe_out_if.source                               dout
);

  localparam int unsigned IDX_W = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHUNK + 1);

  logic [hcbe_pkg::CFG_W-1:0] chunk_size;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [7:0]                 wr_data;
  logic [IDX_W-1:0]           rd_addr;
  logic [7:0]                 rd_data;

  assign pready = 1'b1;

  hcbe_regs #(.MAX_CHUNK(MAX_CHUNK)) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .chunk_size (chunk_size)
  );

  hcbe_store #(.DEPTH(MAX_CHUNK), .IDX_W(IDX_W)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hcbe_seq #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .chunk_size (chunk_size),
    .din        (din),
    .dout       (dout),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

endmodule
`default_nettype wire

@@ src/hcbe_regs.sv @@
// APB configuration register: clamped chunk size.
`default_nettype none
module hcbe_regs #(
  parameter int unsigned MAX_CHUNK = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [hcbe_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [hcbe_pkg::APB_DATA_W-1:0]       pwdata,
  output logic      [hcbe_pkg::APB_DATA_W-1:0]       prdata,
  output logic      [hcbe_pkg::CFG_W-1:0]            chunk_size
);

  localparam logic [hcbe_pkg::CFG_W-1:0] MAX_SIZE = hcbe_pkg::CFG_W'(MAX_CHUNK);
  localparam logic [hcbe_pkg::CFG_W-1:0] RST_SIZE =
    (hcbe_pkg::CHUNK_SIZE_RST > MAX_CHUNK) ? hcbe_pkg::CFG_W'(MAX_CHUNK)
                                           : hcbe_pkg::CFG_W'(hcbe_pkg::CHUNK_SIZE_RST);

  logic                         wr_hit;
  logic [hcbe_pkg::CFG_W-1:0]   wr_raw;
  logic [hcbe_pkg::CFG_W-1:0]   wr_clamped;

  assign wr_hit = psel && penable && pwrite
               && (paddr[hcbe_pkg::APB_ADDR_W-1] == hcbe_pkg::REG_CHUNK_SIZE);
  assign wr_raw = pwdata[hcbe_pkg::CFG_W-1:0];

  always_comb begin
    if (wr_raw == '0) begin
      wr_clamped = hcbe_pkg::CFG_W'(1);
    end else if (wr_raw > MAX_SIZE) begin
      wr_clamped = MAX_SIZE;
    end else begin
      wr_clamped = wr_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= RST_SIZE;
    end else if (wr_hit) begin
      chunk_size <= wr_clamped;
    end
  end

  always_comb begin
    if (paddr[hcbe_pkg::APB_ADDR_W-1] == hcbe_pkg::REG_CHUNK_SIZE) begin
      prdata = hcbe_pkg::APB_DATA_W'(chunk_size);
    end else begin
      prdata = '0;
    end
  end

endmodule
`default_nettype wire

@@ src/hcbe_store.sv @@
// Chunk buffer: single write port, registered read port.
`default_nettype none
module hcbe_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IDX_W = 5
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [7:0]       rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ src/hcbe_seq.sv @@
// Fill tracking, chunk framing sequencer and output register.
`default_nettype none
module hcbe_seq #(
  parameter int unsigned IDX_W     = 5,
  parameter int unsigned CNT_W     = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [hcbe_pkg::CFG_W-1:0]   chunk_size,
  hcbe_in_if.sink                           din,
  hcbe_out_if.source                        dout,
  output logic                              wr_en,
  output logic      [IDX_W-1:0]             wr_addr,
  output logic      [7:0]                   wr_data,
  output logic      [IDX_W-1:0]             rd_addr,
  input  wire logic [7:0]                   rd_data
);

  hcbe_pkg::seq_state_t state, state_next;

  logic [CNT_W-1:0]            fill, fill_next, fill_inc;
  logic [CNT_W-1:0]            len, len_next;
  logic [IDX_W-1:0]            idx, idx_next, idx_last;
  logic                        zero_tail, zero_tail_next;
  logic [hcbe_pkg::CFG_W-1:0]  len6, fill_inc6;
  logic                        accept, push, chunk_full;
  logic [7:0]                  byte_val;
  logic                        last_val, done_val;
  logic                        ovalid;
  logic [7:0]                  obyte;
  logic                        olast, odone;

  assign accept     = din.valid && din.ready;
  assign din.ready  = (state == hcbe_pkg::ST_IDLE);
  assign push       = (state != hcbe_pkg::ST_IDLE) && (!ovalid || dout.ready);
  assign fill_inc   = fill + CNT_W'(1);
  assign fill_inc6  = hcbe_pkg::CFG_W'(fill_inc);
  assign chunk_full = (fill_inc6 >= chunk_size);
  assign len6       = hcbe_pkg::CFG_W'(len);
  assign idx_last   = IDX_W'(len - CNT_W'(1));

  assign wr_en   = accept && (din.func == hcbe_pkg::FUNC_DATA);
  assign wr_addr = IDX_W'(fill);
  assign wr_data = din.data_byte;
  assign rd_addr = idx_next;

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    len_next       = len;
    idx_next       = idx;
    zero_tail_next = zero_tail;
    byte_val       = hcbe_pkg::CHAR_CR;
    last_val       = 1'b0;
    done_val       = 1'b0;
    case (state)
      hcbe_pkg::ST_IDLE: begin
        if (accept) begin
          if (din.func == hcbe_pkg::FUNC_DATA) begin
            if (chunk_full) begin
              len_next       = fill_inc;
              fill_next      = '0;
              zero_tail_next = 1'b0;
              state_next     = (fill_inc6[hcbe_pkg::CFG_W-1:4] != '0) ?
                               hcbe_pkg::ST_HEX_HI : hcbe_pkg::ST_HEX_LO;
            end else begin
              fill_next = fill_inc;
            end
          end else if (fill != '0) begin
            len_next       = fill;
            fill_next      = '0;
            zero_tail_next = 1'b1;
            state_next     = (hcbe_pkg::CFG_W'(fill) >= hcbe_pkg::CFG_W'(16)) ?
                             hcbe_pkg::ST_HEX_HI : hcbe_pkg::ST_HEX_LO;
          end else begin
            state_next = hcbe_pkg::ST_Z0;
          end
        end
      end
      hcbe_pkg::ST_HEX_HI: begin
        byte_val = hcbe_pkg::hex_char({2'b00, len6[5:4]});
        if (push) state_next = hcbe_pkg::ST_HEX_LO;
      end
      hcbe_pkg::ST_HEX_LO: begin
        byte_val = hcbe_pkg::hex_char(len6[3:0]);
        if (push) state_next = hcbe_pkg::ST_CR1;
      end
      hcbe_pkg::ST_CR1: begin
        byte_val = hcbe_pkg::CHAR_CR;
        if (push) state_next = hcbe_pkg::ST_LF1;
      end
      hcbe_pkg::ST_LF1: begin
        byte_val = hcbe_pkg::CHAR_LF;
        if (push) state_next = hcbe_pkg::ST_DATA;
      end
      hcbe_pkg::ST_DATA: begin
        byte_val = rd_data;
        if (push) begin
          if (idx == idx_last) begin
            idx_next   = '0;
            state_next = hcbe_pkg::ST_CR2;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      hcbe_pkg::ST_CR2: begin
        byte_val = hcbe_pkg::CHAR_CR;
        if (push) state_next = hcbe_pkg::ST_LF2;
      end
      hcbe_pkg::ST_LF2: begin
        byte_val = hcbe_pkg::CHAR_LF;
        last_val = !zero_tail;
        if (push) state_next = zero_tail ? hcbe_pkg::ST_Z0 : hcbe_pkg::ST_IDLE;
      end
      hcbe_pkg::ST_Z0: begin
        byte_val = hcbe_pkg::CHAR_ZERO;
        if (push) state_next = hcbe_pkg::ST_ZCR1;
      end
      hcbe_pkg::ST_ZCR1: begin
        byte_val = hcbe_pkg::CHAR_CR;
        if (push) state_next = hcbe_pkg::ST_ZLF1;
      end
      hcbe_pkg::ST_ZLF1: begin
        byte_val = hcbe_pkg::CHAR_LF;
        if (push) state_next = hcbe_pkg::ST_ZCR2;
      end
      hcbe_pkg::ST_ZCR2: begin
        byte_val = hcbe_pkg::CHAR_CR;
        if (push) state_next = hcbe_pkg::ST_ZLF2;
      end
      hcbe_pkg::ST_ZLF2: begin
        byte_val = hcbe_pkg::CHAR_LF;
        last_val = 1'b1;
        done_val = 1'b1;
        if (push) state_next = hcbe_pkg::ST_IDLE;
      end
      default: begin
        state_next = hcbe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hcbe_pkg::ST_IDLE;
      fill      <= '0;
      idx       <= '0;
      zero_tail <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      idx       <= idx_next;
      zero_tail <= zero_tail_next;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (push) begin
      ovalid <= 1'b1;
    end else if (dout.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      obyte <= byte_val;
      olast <= last_val;
      odone <= done_val;
    end
  end

  assign dout.valid     = ovalid;
  assign dout.out_byte  = obyte;
  assign dout.last      = olast;
  assign dout.body_done = odone;

endmodule
`default_nettype wire

@@ src/hcbe_check.sv @@
// Port-level checker for the chunked body encoder, bound to the top level.
`default_nettype none
module hcbe_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_func,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last,
  input wire logic       out_body_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled output byte changed");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_body_done |-> out_last)
    else $error("body_done without last");

  a_done_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_body_done |-> out_byte == hcbe_pkg::CHAR_LF)
    else $error("body_done on a byte other than LF");

  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_func == hcbe_pkg::FUNC_END) |=> !in_ready)
    else $error("end-of-body request did not start the terminator");

endmodule

bind http_chunked_body_encoder hcbe_check u_check (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (din.valid),
  .in_ready      (din.ready),
  .in_func       (din.func),
  .out_valid     (dout.valid),
  .out_ready     (dout.ready),
  .out_byte      (dout.out_byte),
  .out_last      (dout.last),
  .out_body_done (dout.body_done)
);
`default_nettype wire
